FILE: rtl/core/sgde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere grid distance package
// Shared types and constants for the lattice sphere distance pipeline.
// ----------------------------------------------------------------------------
package sgde_pkg;

    localparam int COORD_W  = 40;
    localparam int CFG_W    = 32;
    localparam int DIST_W   = 33;
    localparam int MAG_W    = 31;
    localparam int SQ_W     = 62;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 32;

    localparam logic [CFG_W-1:0] CELL_SIZE_RESET = 32'd655360;
    localparam logic [CFG_W-1:0] RADIUS_RESET    = 32'd65536;

    typedef enum logic [0:0] {
        CFG_CELL_SIZE = 1'b0,
        CFG_RADIUS    = 1'b1
    } cfg_index_t;

    // One lane of the restoring divider as it passes from cell to cell.
    typedef struct packed {
        logic [CFG_W-1:0]   rem;
        logic [COORD_W-1:0] dvd;
        logic               q_lsb;
    } div_lane_t;

    // Square root working pair.
    typedef struct packed {
        logic [SUM_W-1:0] v;
        logic [SUM_W-1:0] res;
    } sqrt_lane_t;

endpackage

FILE: rtl/core/sphere_grid_distance_estimate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere grid distance estimate
// Signed distance from a point to the nearest sphere of a cubic lattice.
// ----------------------------------------------------------------------------
// The pipeline runs through 40 divider cells, fold, square, sum, 32 root cells
// and the output register. Throughput is one point per cycle; the whole
// chain holds while a finished result waits on out_ready.
// Reset clears the stage valid bits and loads the default cell size (10.0)
// and radius (1.0); the datapath registers are not reset.
module sphere_grid_distance_estimate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [sgde_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [sgde_pkg::COORD_W-1:0] x_coord,
    input  logic signed [sgde_pkg::COORD_W-1:0] y_coord,
    input  logic signed [sgde_pkg::COORD_W-1:0] z_coord,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [sgde_pkg::DIST_W-1:0] distance
);
    import sgde_pkg::*;

    localparam int DIV_N  = COORD_W;
    localparam int ROOT_N = ROOT_W;
    localparam int STAGES = DIV_N + 3 + ROOT_N + 1;

    logic [CFG_W-1:0]  cell_size_reg;
    logic [CFG_W-1:0]  radius_reg;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic              en;

    div_lane_t         div_chain [3][DIV_N+1];
    logic [SQ_W-1:0]   sq [3];
    logic [SUM_W-1:0]  sum_reg;
    sqrt_lane_t        root_chain [ROOT_N+1];
    logic [DIST_W-1:0] dist_reg;
    logic [COORD_W-1:0] coord_abs [3];

    assign en       = !vld_reg[STAGES-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= CELL_SIZE_RESET;
            radius_reg    <= RADIUS_RESET;
            vld_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CELL_SIZE: cell_size_reg <= cfg_data;
                    CFG_RADIUS:    radius_reg    <= cfg_data;
                    default:       ;
                endcase
            end
            if (en)
            begin
                vld_reg <= vld_next;
            end
        end
    end

    // The sign is dropped here; only the magnitude of the remainder matters.
    always_comb
    begin
        coord_abs[0] = x_coord[COORD_W-1] ? COORD_W'(-x_coord) : COORD_W'(x_coord);
        coord_abs[1] = y_coord[COORD_W-1] ? COORD_W'(-y_coord) : COORD_W'(y_coord);
        coord_abs[2] = z_coord[COORD_W-1] ? COORD_W'(-z_coord) : COORD_W'(z_coord);
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        assign div_chain[a][0].rem   = '0;
        assign div_chain[a][0].dvd   = coord_abs[a];
        assign div_chain[a][0].q_lsb = 1'b0;

        for (genvar k = 0; k < DIV_N; k++)
        begin : g_div
            sgde_div_cell u_cell (
                .clk       (clk),
                .en        (en),
                .cell_size (cell_size_reg),
                .lane_in   (div_chain[a][k]),
                .lane_out  (div_chain[a][k+1])
            );
        end

        sgde_fold u_fold (
            .clk       (clk),
            .en        (en),
            .cell_size (cell_size_reg),
            .lane_in   (div_chain[a][DIV_N]),
            .sq        (sq[a])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
            dist_reg <= {1'b0, root_chain[ROOT_N].res[ROOT_W-1:0]} - {1'b0, radius_reg};
        end
    end

    assign root_chain[0].v   = sum_reg;
    assign root_chain[0].res = '0;

    for (genvar k = 0; k < ROOT_N; k++)
    begin : g_root
        sgde_sqrt_cell #(.BIT_POS(ROOT_N - 1 - k)) u_cell (
            .clk      (clk),
            .en       (en),
            .lane_in  (root_chain[k]),
            .lane_out (root_chain[k+1])
        );
    end

    assign out_valid = vld_reg[STAGES-1];
    assign distance  = dist_reg;
endmodule

FILE: rtl/core/sgde_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: takes the next dividend bit into the
// remainder and subtracts the cell size where it fits.
// ----------------------------------------------------------------------------
module sgde_div_cell (
    input  logic                     clk,
    input  logic                     en,
    input  logic [sgde_pkg::CFG_W-1:0] cell_size,
    input  sgde_pkg::div_lane_t      lane_in,
    output sgde_pkg::div_lane_t      lane_out
);
    import sgde_pkg::*;

    logic [CFG_W:0] trial;
    logic [CFG_W:0] diff;
    logic           fits;
    div_lane_t      lane_next;
    div_lane_t      lane_reg;

    always_comb
    begin
        trial = {lane_in.rem, lane_in.dvd[COORD_W-1]};
        diff  = trial - {1'b0, cell_size};
        fits  = (trial >= {1'b0, cell_size});
        lane_next.rem   = fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
        lane_next.dvd   = {lane_in.dvd[COORD_W-2:0], 1'b0};
        lane_next.q_lsb = fits;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;
endmodule

FILE: rtl/core/sgde_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder fold and square
// Turns a plain remainder into the magnitude of the symmetric remainder,
// rounding the quotient to nearest with ties to even, then squares it.
// ----------------------------------------------------------------------------
module sgde_fold (
    input  logic                       clk,
    input  logic                       en,
    input  logic [sgde_pkg::CFG_W-1:0] cell_size,
    input  sgde_pkg::div_lane_t        lane_in,
    output logic [sgde_pkg::SQ_W-1:0]  sq
);
    import sgde_pkg::*;

    logic [CFG_W:0]   twice_r;
    logic [CFG_W-1:0] mag_full;
    logic             wrap;
    logic [MAG_W-1:0] mag_reg;
    logic [SQ_W-1:0]  sq_reg;

    always_comb
    begin
        twice_r = {lane_in.rem, 1'b0};
        wrap    = (twice_r > {1'b0, cell_size})
                  || ((twice_r == {1'b0, cell_size}) && lane_in.q_lsb);
        if (cell_size == '0)
        begin
            mag_full = '0;
        end
        else if (wrap)
        begin
            mag_full = cell_size - lane_in.rem;
        end
        else
        begin
            mag_full = lane_in.rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_full[MAG_W-1:0];
            sq_reg  <= {{(SQ_W-MAG_W){1'b0}}, mag_reg} * {{(SQ_W-MAG_W){1'b0}}, mag_reg};
        end
    end

    assign sq = sq_reg;
endmodule

FILE: rtl/core/sgde_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One step of the digit-by-digit integer square root at a fixed bit pair.
// ----------------------------------------------------------------------------
module sgde_sqrt_cell #(
    parameter int BIT_POS = 31
) (
    input  logic                  clk,
    input  logic                  en,
    input  sgde_pkg::sqrt_lane_t  lane_in,
    output sgde_pkg::sqrt_lane_t  lane_out
);
    import sgde_pkg::*;

    localparam logic [SUM_W-1:0] STEP_BIT = SUM_W'(1) << (2 * BIT_POS);

    logic [SUM_W-1:0] trial;
    sqrt_lane_t       lane_next;
    sqrt_lane_t       lane_reg;

    always_comb
    begin
        trial = lane_in.res + STEP_BIT;
        if (lane_in.v >= trial)
        begin
            lane_next.v   = lane_in.v - trial;
            lane_next.res = (lane_in.res >> 1) + STEP_BIT;
        end
        else
        begin
            lane_next.v   = lane_in.v;
            lane_next.res = lane_in.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;
endmodule

FILE: rtl/core/sgde_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere grid distance checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sgde_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [sgde_pkg::DIST_W-1:0] distance
);
    import sgde_pkg::*;

    // A waiting result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance))
        else $error("result beat changed while stalled");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track output stall");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result beat present straight after reset");
endmodule

bind sphere_grid_distance_estimate sgde_checker u_sgde_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .distance  (distance)
);
